FILE: hdl/tbcd_pkg.sv
`timescale 1ns / 1ps

package tbcd_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CLICK_MS_W = 16;
    localparam int unsigned CFG_IDX_W  = 8;

    localparam logic [CLICK_MS_W-1:0] MIN_CLICK_RESET = 16'd40;
    localparam logic [CLICK_MS_W-1:0] MAX_CLICK_RESET = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_CLICK_MS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CLICK_MS = 8'd1;

    typedef struct packed {
        logic prev;
        logic handled;
        logic [TIME_W-1:0] down_time;
    } button_state_t;

endpackage

FILE: hdl/tbcd_if.sv
`timescale 1ns / 1ps

interface tbcd_sample_if;
    import tbcd_pkg::*;

    logic              valid;
    logic              ready;
    logic              first_pressed;
    logic              second_pressed;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output first_pressed, output second_pressed,
                    output now_ms, input ready);
    modport sink   (input valid, input first_pressed, input second_pressed,
                    input now_ms, output ready);
endinterface

interface tbcd_result_if;
    logic valid;
    logic ready;
    logic first_click;
    logic second_click;
    logic chord_event;

    modport source (output valid, output first_click, output second_click,
                    output chord_event, input ready);
    modport sink   (input valid, input first_click, input second_click,
                    input chord_event, output ready);
endinterface

interface tbcd_cfg_if;
    import tbcd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CLICK_MS_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/two_button_click_chord_detector.sv
`timescale 1ns / 1ps

// Two-button click and chord detector.
// Channels: "in" carries one poll sample per item (both button levels and a
// wrapping millisecond timestamp); "out" returns exactly one result item per
// sample (first_click, second_click, chord_event); "cfg" writes the click
// window, index 0 min_click_ms and index 1 max_click_ms, other indexes ignored.
// cfg is always ready; write it only while no sample is in flight.
// Latency: the result of a sample is presented on "out" in the cycle after it
// is accepted, from the result register.
// Throughput: one sample per cycle; the single update of the per-button state
// between sample and result register sets that figure.
// When the receiver stalls, the result register holds and "in" takes a new
// sample only in a cycle in which the held result is taken.
// Reset clears the button state, the chord latch and the result register and
// restores the window to 40 ms and 1000 ms.
module two_button_click_chord_detector (
    input logic         clk,
    input logic         rst_n,
    tbcd_sample_if.sink in,
    tbcd_result_if.source out,
    tbcd_cfg_if.sink    cfg
);
    import tbcd_pkg::*;

    logic [CLICK_MS_W-1:0] min_click_reg;
    logic [CLICK_MS_W-1:0] max_click_reg;
    button_state_t         first_reg, first_next;
    button_state_t         second_reg, second_next;
    logic                  chord_latched_reg, chord_latched_next;
    logic                  out_valid_reg;
    logic                  first_click_reg, first_click_next;
    logic                  second_click_reg, second_click_next;
    logic                  chord_event_reg, chord_event_next;
    logic                  accept;

    function automatic logic button_step(
        input  logic                  cur,
        input  button_state_t         st,
        input  logic [TIME_W-1:0]     now,
        input  logic [CLICK_MS_W-1:0] lo,
        input  logic [CLICK_MS_W-1:0] hi,
        output button_state_t         st_next
    );
        logic [TIME_W-1:0] held;
        logic              click;
        held    = now - st.down_time;
        click   = 1'b0;
        st_next = st;
        if (cur && !st.prev)
        begin
            st_next.down_time = now;
            st_next.handled   = 1'b0;
        end
        else if (!cur && st.prev)
        begin
            if (!st.handled && held >= TIME_W'(lo) && held < TIME_W'(hi))
            begin
                st_next.handled = 1'b1;
                click           = 1'b1;
            end
        end
        st_next.prev = cur;
        return click;
    endfunction

    assign in.ready  = !out_valid_reg || out.ready;
    assign accept    = in.valid && in.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        first_next         = first_reg;
        second_next        = second_reg;
        chord_latched_next = chord_latched_reg;
        first_click_next   = 1'b0;
        second_click_next  = 1'b0;
        chord_event_next   = 1'b0;
        if (in.first_pressed && in.second_pressed && !chord_latched_reg)
        begin
            chord_latched_next  = 1'b1;
            first_next.handled  = 1'b1;
            second_next.handled = 1'b1;
            chord_event_next    = 1'b1;
        end
        else
        begin
            if (!in.first_pressed && !in.second_pressed)
            begin
                chord_latched_next = 1'b0;
            end
            first_click_next  = button_step(in.first_pressed, first_reg, in.now_ms,
                                            min_click_reg, max_click_reg, first_next);
            second_click_next = button_step(in.second_pressed, second_reg, in.now_ms,
                                            min_click_reg, max_click_reg, second_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_click_reg     <= MIN_CLICK_RESET;
            max_click_reg     <= MAX_CLICK_RESET;
            first_reg         <= '0;
            second_reg        <= '0;
            chord_latched_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            first_click_reg   <= 1'b0;
            second_click_reg  <= 1'b0;
            chord_event_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_MIN_CLICK_MS: min_click_reg <= cfg.data;
                    REG_MAX_CLICK_MS: max_click_reg <= cfg.data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                first_reg         <= first_next;
                second_reg        <= second_next;
                chord_latched_reg <= chord_latched_next;
                first_click_reg   <= first_click_next;
                second_click_reg  <= second_click_next;
                chord_event_reg   <= chord_event_next;
                out_valid_reg     <= 1'b1;
            end
            else if (out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out.valid        = out_valid_reg;
    assign out.first_click  = first_click_reg;
    assign out.second_click = second_click_reg;
    assign out.chord_event  = chord_event_reg;

`ifndef SYNTHESIS
    a_chord_excludes_click: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && chord_event_reg |-> !first_click_reg && !second_click_reg)
        else $error("chord result carries a click");

    a_chord_sets_latch: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in.first_pressed && in.second_pressed && !chord_latched_reg
        |=> chord_latched_reg && first_reg.handled && second_reg.handled)
        else $error("chord did not latch");

    a_release_clears_latch: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !in.first_pressed && !in.second_pressed |=> !chord_latched_reg)
        else $error("chord latch held after release");

    a_click_marks_handled: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (first_click_next || second_click_next)
        |=> (first_reg.handled || !first_click_reg)
            && (second_reg.handled || !second_click_reg))
        else $error("click left button unhandled");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import tbcd_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_TICKS = 3;
    localparam int DIRECTED_N   = 25;

    localparam logic [CFG_IDX_W-1:0] REG_STRAY_TOP = {CFG_IDX_W{1'b1}};

    typedef struct packed {
        logic first_click;
        logic second_click;
        logic chord_event;
    } click_result_t;

    localparam click_result_t NO_CLICK    = 3'b000;
    localparam click_result_t FIRST_CLICK = 3'b100;
    localparam click_result_t CHORD_ONLY  = 3'b001;

    typedef struct packed {
        logic              first;
        logic              second;
        logic [TIME_W-1:0] stamp;
        logic              typed;
        click_result_t     want;
    } poll_row_t;

    logic clk = 1'b0;
    logic rst_n;

    tbcd_sample_if sample_bus ();
    tbcd_result_if result_bus ();
    tbcd_cfg_if    cfg_bus ();

    two_button_click_chord_detector DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (sample_bus),
        .out   (result_bus),
        .cfg   (cfg_bus)
    );

    always #6 clk = ~clk;

    click_result_t         pending_clicks[$];
    button_state_t         buttons[2];
    logic                  chord_latch;
    logic [CLICK_MS_W-1:0] win_min;
    logic [CLICK_MS_W-1:0] win_max;
    logic [TIME_W-1:0]     stamp_ms;
    int                    error_count;
    int                    items_sent;
    int                    src_idle_pct;
    int                    snk_idle_pct;
    int unsigned           hold_asked;
    int unsigned           hold_served;
    int                    hold_left;

    poll_row_t directed_polls [DIRECTED_N] = '{
        '{1'b0, 1'b0, 32'd0,          1'b1, NO_CLICK},
        '{1'b1, 1'b0, 32'd100,        1'b1, NO_CLICK},
        '{1'b0, 1'b0, 32'd140,        1'b1, FIRST_CLICK},
        '{1'b0, 1'b1, 32'd200,        1'b1, NO_CLICK},
        '{1'b0, 1'b0, 32'd1200,       1'b1, NO_CLICK},
        '{1'b1, 1'b0, 32'd2000,       1'b1, NO_CLICK},
        '{1'b0, 1'b0, 32'd2999,       1'b1, FIRST_CLICK},
        '{1'b0, 1'b1, 32'd3000,       1'b1, NO_CLICK},
        '{1'b0, 1'b0, 32'd3039,       1'b1, NO_CLICK},
        '{1'b1, 1'b1, 32'd4000,       1'b1, CHORD_ONLY},
        '{1'b1, 1'b1, 32'd4010,       1'b0, NO_CLICK},
        '{1'b0, 1'b1, 32'd4100,       1'b0, NO_CLICK},
        '{1'b0, 1'b0, 32'd4200,       1'b0, NO_CLICK},
        '{1'b1, 1'b0, 32'd5000,       1'b1, NO_CLICK},
        '{1'b1, 1'b1, 32'd5100,       1'b1, CHORD_ONLY},
        '{1'b1, 1'b0, 32'd5200,       1'b0, NO_CLICK},
        '{1'b0, 1'b0, 32'd5300,       1'b0, NO_CLICK},
        '{1'b1, 1'b0, 32'hFFFF_FFF0,  1'b1, NO_CLICK},
        '{1'b0, 1'b0, 32'h0000_0030,  1'b0, NO_CLICK},
        '{1'b0, 1'b1, 32'hFFFF_FFFF,  1'b1, NO_CLICK},
        '{1'b0, 1'b0, 32'hFFFF_FFFF,  1'b0, NO_CLICK},
        '{1'b1, 1'b1, 32'h0000_0000,  1'b1, CHORD_ONLY},
        '{1'b0, 1'b0, 32'h0000_0001,  1'b0, NO_CLICK},
        '{1'b1, 1'b0, 32'h0000_0002,  1'b1, NO_CLICK},
        '{1'b0, 1'b0, 32'hFFFF_FFFF,  1'b0, NO_CLICK}
    };

    function automatic logic step_button(input int unsigned k, input logic level,
                                         input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] held;
        logic              hit;
        held = t - buttons[k].down_time;
        hit  = 1'b0;
        if (level && !buttons[k].prev)
        begin
            buttons[k].down_time = t;
            buttons[k].handled   = 1'b0;
        end
        else if (!level && buttons[k].prev)
        begin
            if (!buttons[k].handled && held >= TIME_W'(win_min)
                && held < TIME_W'(win_max))
            begin
                buttons[k].handled = 1'b1;
                hit = 1'b1;
            end
        end
        buttons[k].prev = level;
        return hit;
    endfunction

    function automatic click_result_t predict_clicks(input logic f, input logic s,
                                                     input logic [TIME_W-1:0] t);
        click_result_t res;
        res = NO_CLICK;
        if (f && s)
        begin
            if (!chord_latch)
            begin
                // chord sample: flag it and skip the per-button update
                chord_latch        = 1'b1;
                buttons[0].handled = 1'b1;
                buttons[1].handled = 1'b1;
                res.chord_event    = 1'b1;
                return res;
            end
        end
        else if (!f && !s)
        begin
            chord_latch = 1'b0;
        end
        res.first_click  = step_button(0, f, t);
        res.second_click = step_button(1, s, t);
        return res;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CLICK_MS_W-1:0] val);
        if (idx == REG_MIN_CLICK_MS)
            win_min = val;
        else if (idx == REG_MAX_CLICK_MS)
            win_max = val;
    endfunction

    function automatic logic [TIME_W-1:0] pick_hold();
        logic [TIME_W-1:0] h;
        case ($urandom_range(0, 7))
            0: h = TIME_W'(win_min);
            1: h = TIME_W'(win_min) - 1;
            2: h = TIME_W'(win_max);
            3: h = TIME_W'(win_max) - 1;
            4: h = $urandom_range(0, 60);
            7: h = $urandom();
            default: h = $urandom_range(win_min, win_max);
        endcase
        return h;
    endfunction

    task automatic send_sample(input logic f, input logic s, input logic [TIME_W-1:0] t,
                               input logic typed = 1'b0,
                               input click_result_t want = NO_CLICK);
        click_result_t predicted;
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid          <= 1'b1;
        sample_bus.first_pressed  <= f;
        sample_bus.second_pressed <= s;
        sample_bus.now_ms         <= t;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        predicted = predict_clicks(f, s, t);
        pending_clicks.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic wait_drained();
        sample_bus.valid <= 1'b0;
        while (pending_clicks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic program_window(input logic [CLICK_MS_W-1:0] lo,
                                  input logic [CLICK_MS_W-1:0] hi);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CLICK_MS_W-1:0] val [3];
        idx[0] = REG_MIN_CLICK_MS;
        val[0] = lo;
        idx[1] = $urandom_range(0, 1) ? REG_STRAY_TOP
                 : CFG_IDX_W'($urandom_range(REG_MAX_CLICK_MS + 1, REG_STRAY_TOP));
        val[1] = CLICK_MS_W'($urandom());
        idx[2] = REG_MAX_CLICK_MS;
        val[2] = hi;
        for (int k = 0; k < 3; k++)
        begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx[k];
            cfg_bus.data  <= val[k];
            @(posedge clk);
            while (!cfg_bus.ready)
                @(posedge clk);
            apply_reg(idx[k], val[k]);
        end
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic run_gestures(input int count);
        int                target;
        logic [TIME_W-1:0] hold;
        logic              lead;
        target = items_sent + count;
        stamp_ms = ($urandom_range(0, 2) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 4000)
                                               : $urandom();
        while (items_sent < target)
        begin
            hold = pick_hold();
            lead = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    send_sample(lead, !lead, stamp_ms);
                    send_sample(lead, !lead, stamp_ms + (hold >> 1));
                    stamp_ms += hold;
                    send_sample(1'b0, 1'b0, stamp_ms);
                end
                6, 7:
                begin
                    send_sample(1'b1, 1'b1, stamp_ms);
                    send_sample(1'b1, 1'b1, stamp_ms + (hold >> 1));
                    stamp_ms += hold;
                    send_sample(lead, !lead, stamp_ms);
                    stamp_ms += pick_hold();
                    send_sample(1'b0, 1'b0, stamp_ms);
                end
                8:
                begin
                    repeat ($urandom_range(3, 6))
                    begin
                        stamp_ms += pick_hold();
                        send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                    stamp_ms);
                    end
                end
                default:
                begin
                    send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                $urandom());
                end
            endcase
            stamp_ms += $urandom_range(0, 50);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        click_result_t got;
        click_result_t want;
        if (result_bus.valid && result_bus.ready)
        begin
            got.first_click  = result_bus.first_click;
            got.second_click = result_bus.second_click;
            got.chord_event  = result_bus.chord_event;
            if (pending_clicks.size() == 0)
            begin
                $error("result item with nothing pending: %b", got);
                error_count++;
            end
            else
            begin
                want = pending_clicks.pop_front();
                if (got.first_click !== want.first_click)
                begin
                    $error("first_click: expected %0b, got %0b",
                           want.first_click, got.first_click);
                    error_count++;
                end
                if (got.second_click !== want.second_click)
                begin
                    $error("second_click: expected %0b, got %0b",
                           want.second_click, got.second_click);
                    error_count++;
                end
                if (got.chord_event !== want.chord_event)
                begin
                    $error("chord_event: expected %0b, got %0b",
                           want.chord_event, got.chord_event);
                    error_count++;
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_bus.ready <= 1'b0;
        end
        else if (hold_asked != hold_served)
        begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            result_bus.ready <= 1'b0;
        end
        else
        begin
            result_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        logic [CLICK_MS_W-1:0] lo;
        logic [CLICK_MS_W-1:0] hi;
        rst_n                     = 1'b0;
        sample_bus.valid          = 1'b0;
        sample_bus.first_pressed  = 1'b0;
        sample_bus.second_pressed = 1'b0;
        sample_bus.now_ms         = '0;
        result_bus.ready          = 1'b0;
        cfg_bus.valid             = 1'b0;
        cfg_bus.index             = '0;
        cfg_bus.data              = '0;
        buttons[0]                = '0;
        buttons[1]                = '0;
        chord_latch               = 1'b0;
        win_min                   = MIN_CLICK_RESET;
        win_max                   = MAX_CLICK_RESET;
        error_count               = 0;
        items_sent                = 0;
        hold_asked                = 0;
        hold_served               = 0;
        hold_left                 = 0;
        src_idle_pct              = 31;
        snk_idle_pct              = 80;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_N; r++)
            send_sample(directed_polls[r].first, directed_polls[r].second,
                        directed_polls[r].stamp, directed_polls[r].typed,
                        directed_polls[r].want);
        run_gestures(250);

        wait_drained();
        program_window('0, '1);
        run_gestures(250);

        wait_drained();
        program_window('1, '0);
        run_gestures(120);

        src_idle_pct = 80;
        snk_idle_pct = 31;
        for (int p = 0; p < 3; p++)
        begin
            wait_drained();
            lo = CLICK_MS_W'($urandom_range(0, 300));
            hi = (p == 2) ? lo : CLICK_MS_W'($urandom_range(0, 2000));
            program_window(lo, hi);
            run_gestures(150);
        end

        // stall the receiver while samples keep coming, then drain
        src_idle_pct = 0;
        snk_idle_pct = 0;
        wait_drained();
        program_window(MIN_CLICK_RESET, MAX_CLICK_RESET);
        hold_asked++;
        run_gestures(30);
        wait_drained();

        run_gestures(400);
        wait_drained();
        program_window(CLICK_MS_W'($urandom_range(0, 200)),
                       CLICK_MS_W'($urandom_range(100, 3000)));
        run_gestures(400);
        wait_drained();

        if (error_count == 0 && pending_clicks.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
hdl/tbcd_pkg.sv
hdl/tbcd_if.sv
hdl/two_button_click_chord_detector.sv
tb/tb_top.sv
